>>> hdl/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types and constants for the counting semaphore bank with wait queues.
// ----------------------------------------------------------------------------
`default_nettype none

package csem_pkg;

  localparam int unsigned KindW     = 1;
  localparam int unsigned IndexW    = 4;
  localparam int unsigned PidW      = 8;
  localparam int unsigned CountW    = 8;
  localparam int unsigned OutcomeW  = 3;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned RcW       = 3;

  // widest stored requester id supported
  localparam int unsigned PidMaxW   = 16;

  localparam int unsigned NumInitRegs = 4;
  localparam int unsigned InitIdxW    = 2;

  localparam logic [CountW-1:0] CountMax   = 8'hFF;
  localparam logic [CountW-1:0] CountReset = 8'd1;
  localparam logic [RcW-1:0]    RcReset    = 3'd4;

  localparam logic [KindW-1:0] KIND_WAIT   = 1'b0;
  localparam logic [KindW-1:0] KIND_SIGNAL = 1'b1;

  localparam logic [CfgIndexW-1:0] CFG_RESOURCE_COUNT = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_INIT_FIRST     = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_INIT_LAST      = 3'd4;

  typedef enum logic [OutcomeW-1:0] {
    OUT_GRANTED  = 3'd0,
    OUT_BLOCKED  = 3'd1,
    OUT_RELEASED = 3'd2,
    OUT_HANDED   = 3'd3,
    OUT_INVALID  = 3'd4,
    OUT_FULL     = 3'd5
  } outcome_e;

  typedef logic [NumInitRegs-1:0][CountW-1:0] init_vec_t;

  typedef struct packed {
    outcome_e          outcome;
    logic [CountW-1:0] instances_left;
  } step_res_t;

  typedef struct packed {
    logic      reload;
    init_vec_t init_counts;
  } reload_t;

endpackage

`default_nettype wire

>>> hdl/csem_if.sv
// ----------------------------------------------------------------------------
// csem_if
// Valid/ready channels of the semaphore bank: request, result and config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface csem_req_if
  import csem_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [IndexW-1:0] resource_index;
  logic [PidW-1:0]   requester_pid;

  modport source (output valid, kind, resource_index, requester_pid, input ready);
  modport sink   (input valid, kind, resource_index, requester_pid, output ready);
endinterface

interface csem_res_if
  import csem_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OutcomeW-1:0] outcome;
  logic [PidW-1:0]     woken_pid;
  logic [CountW-1:0]   instances_left;

  modport source (output valid, outcome, woken_pid, instances_left, input ready);
  modport sink   (input valid, outcome, woken_pid, instances_left, output ready);
endinterface

interface csem_cfg_if
  import csem_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl
// Per-semaphore counts, queue pointers and the waiter memory; one accepted request
// per cycle as a single read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_ctrl
  import csem_pkg::*;
#(
  parameter int unsigned NUM_SEMAPHORES = 4,
  parameter int unsigned QUEUE_DEPTH    = 8,
  parameter int unsigned PID_BITS       = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire reload_t           reload_i,
  input  wire logic [RcW-1:0]    resource_count_i,
  input  wire logic              accept_i,
  input  wire logic [KindW-1:0]  kind_i,
  input  wire logic [IndexW-1:0] resource_index_i,
  input  wire logic [PidW-1:0]   requester_pid_i,
  output step_res_t              step_o,
  output logic [PidW-1:0]        woken_pid_o
);

  localparam int unsigned SemW  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int unsigned PtrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AddrW = SemW + PtrW;
  localparam int unsigned MemDepth = 1 << AddrW;

  localparam logic [PtrW-1:0]   PtrLast  = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0]  FillFull = FillW'(QUEUE_DEPTH);
  localparam logic [IndexW:0]   NumSemX  = (IndexW + 1)'(NUM_SEMAPHORES);

  logic [CountW-1:0] count_q [NUM_SEMAPHORES];
  logic [PtrW-1:0]   head_q  [NUM_SEMAPHORES];
  logic [PtrW-1:0]   tail_q  [NUM_SEMAPHORES];
  logic [FillW-1:0]  fill_q  [NUM_SEMAPHORES];

  logic [PID_BITS-1:0] wait_mem [MemDepth];
  logic [PID_BITS-1:0] rd_data_q;
  logic                handed_q;

  logic              sem_valid;
  logic [SemW-1:0]   sem;
  logic [CountW-1:0] cnt_cur;
  logic [CountW-1:0] cnt_new;
  logic [FillW-1:0]  fill_cur;
  logic [PtrW-1:0]   head_cur;
  logic [PtrW-1:0]   tail_cur;
  logic              do_enq;
  logic              do_deq;
  logic [PidMaxW-1:0] pid_wide;
  logic [PidMaxW-1:0] rd_wide;
  logic [PID_BITS-1:0] pid_store;

  assign sem_valid = ({1'b0, resource_index_i} < (IndexW + 1)'(resource_count_i)) &&
                     ({1'b0, resource_index_i} < NumSemX);
  assign sem      = resource_index_i[SemW-1:0];
  assign cnt_cur  = count_q[sem];
  assign fill_cur = fill_q[sem];
  assign head_cur = head_q[sem];
  assign tail_cur = tail_q[sem];

  assign pid_wide  = PidMaxW'(requester_pid_i);
  assign pid_store = pid_wide[PID_BITS-1:0];

  always_comb begin
    step_o.outcome        = OUT_INVALID;
    step_o.instances_left = '0;
    cnt_new               = cnt_cur;
    do_enq                = 1'b0;
    do_deq                = 1'b0;
    if (sem_valid) begin
      if (kind_i == KIND_WAIT) begin
        if (cnt_cur != '0) begin
          cnt_new        = cnt_cur - 1'b1;
          step_o.outcome = OUT_GRANTED;
        end else if (fill_cur == FillFull) begin
          step_o.outcome = OUT_FULL;
        end else begin
          do_enq         = 1'b1;
          step_o.outcome = OUT_BLOCKED;
        end
      end else begin
        if (fill_cur != '0) begin
          do_deq         = 1'b1;
          step_o.outcome = OUT_HANDED;
        end else begin
          // count saturates at its maximum
          if (cnt_cur != CountMax) begin
            cnt_new = cnt_cur + 1'b1;
          end
          step_o.outcome = OUT_RELEASED;
        end
      end
      step_o.instances_left = cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned s = 0; s < NUM_SEMAPHORES; s++) begin
        count_q[s] <= (s < NumInitRegs) ? CountReset : '0;
        head_q[s]  <= '0;
        tail_q[s]  <= '0;
        fill_q[s]  <= '0;
      end
      handed_q <= 1'b0;
    end else if (reload_i.reload) begin
      // queues stay as they are, only the counts reload
      for (int unsigned s = 0; s < NUM_SEMAPHORES; s++) begin
        count_q[s] <= (s < NumInitRegs) ? reload_i.init_counts[s[InitIdxW-1:0]] : '0;
      end
    end else if (accept_i) begin
      handed_q <= do_deq;
      if (sem_valid) begin
        count_q[sem] <= cnt_new;
      end
      if (do_enq) begin
        tail_q[sem] <= (tail_cur == PtrLast) ? '0 : tail_cur + 1'b1;
        fill_q[sem] <= fill_cur + 1'b1;
      end
      if (do_deq) begin
        head_q[sem] <= (head_cur == PtrLast) ? '0 : head_cur + 1'b1;
        fill_q[sem] <= fill_cur - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && do_enq) begin
      wait_mem[{sem, tail_cur}] <= pid_store;
    end
    if (accept_i && do_deq) begin
      rd_data_q <= wait_mem[{sem, head_cur}];
    end
  end

  assign rd_wide     = PidMaxW'(rd_data_q);
  assign woken_pid_o = handed_q ? rd_wide[PidW-1:0] : '0;

endmodule

`default_nettype wire

>>> hdl/counting_semaphore_with_wait_queues.sv
// ----------------------------------------------------------------------------
// counting_semaphore_with_wait_queues
// Bank of counting semaphores with FIFO wait queues and a config write port.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns exactly one result per request,
// registered at its transfer. While a result waits to be taken the request side
// is held off; a new request is let in at the same edge that the previous
// result is taken, so a sink that is always ready sees one result per clock.
// The rate is set by the single read-modify-write of the addressed counter and
// queue pointers, plus one synchronous read of the waiter memory on handover.
// Config writes are always ready; any write to a listed register reloads every
// count from the initial instance registers and leaves the queues untouched.
// The waiter memory has no clearing pass: the fill counts guard every read.
`default_nettype none

module counting_semaphore_with_wait_queues
  import csem_pkg::*;
#(
  parameter int unsigned NUM_SEMAPHORES = 4,
  parameter int unsigned QUEUE_DEPTH    = 8,
  parameter int unsigned PID_BITS       = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  csem_cfg_if.sink    cfg_i,
  csem_req_if.sink    req_i,
  csem_res_if.source  res_o
);

  logic [RcW-1:0] resource_count_q;
  init_vec_t      init_q;
  init_vec_t      init_d;
  reload_t        reload;
  logic [CfgIndexW-1:0] init_off;

  logic      accept;
  logic      res_valid_q;
  step_res_t step;
  step_res_t step_q;
  logic [PidW-1:0] woken;

  // config decode
  assign cfg_i.ready = 1'b1;
  assign init_off    = cfg_i.index - CFG_INIT_FIRST;

  always_comb begin
    init_d        = init_q;
    reload.reload = 1'b0;
    if (cfg_i.valid) begin
      if (cfg_i.index == CFG_RESOURCE_COUNT) begin
        reload.reload = 1'b1;
      end else if (cfg_i.index inside {[CFG_INIT_FIRST:CFG_INIT_LAST]}) begin
        init_d[init_off[InitIdxW-1:0]] = cfg_i.data;
        reload.reload = 1'b1;
      end
    end
    reload.init_counts = init_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resource_count_q <= RcReset;
      for (int unsigned r = 0; r < NumInitRegs; r++) begin
        init_q[r] <= CountReset;
      end
    end else if (cfg_i.valid) begin
      init_q <= init_d;
      if (cfg_i.index == CFG_RESOURCE_COUNT) begin
        resource_count_q <= cfg_i.data[RcW-1:0];
      end
    end
  end

  // result register
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  csem_ctrl #(
    .NUM_SEMAPHORES (NUM_SEMAPHORES),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .PID_BITS       (PID_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .reload_i         (reload),
    .resource_count_i (resource_count_q),
    .accept_i         (accept),
    .kind_i           (req_i.kind),
    .resource_index_i (req_i.resource_index),
    .requester_pid_i  (req_i.requester_pid),
    .step_o           (step),
    .woken_pid_o      (woken)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      step_q <= step;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.outcome        = step_q.outcome;
  assign res_o.instances_left = step_q.instances_left;
  assign res_o.woken_pid      = woken;

endmodule

`default_nettype wire

>>> bench/tb_counting_semaphore_with_wait_queues.sv
// ----------------------------------------------------------------------------
// tb_counting_semaphore_with_wait_queues
// Self-checking bench for the semaphore bank with FIFO wait queues: a directed
// opening pass, then random request traffic under several register settings,
// with bursty requests and a stalling result sink. Every result is compared
// against an in-bench model of counts and wait queues.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_counting_semaphore_with_wait_queues;
  timeunit 1ns;
  timeprecision 1ps;

  import csem_pkg::*;

  localparam int unsigned NumSem     = 4;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxShown   = 10;

  // register indexes past the list, which the block ignores
  localparam logic [CfgIndexW-1:0] CfgUnusedLo = CFG_INIT_LAST + 3'd1;
  localparam logic [CfgIndexW-1:0] CfgUnusedHi = '1;

  typedef struct packed {
    outcome_e          outcome;
    logic [PidW-1:0]   woken_pid;
    logic [CountW-1:0] instances_left;
  } sem_result_t;

  class sem_scoreboard;
    logic [RcW-1:0]    active_count;
    logic [CountW-1:0] init_count [NumInitRegs];
    logic [CountW-1:0] avail [NumSem];
    logic [PidW-1:0]   waiters [NumSem][QueueDepth];
    int unsigned       head [NumSem];
    int unsigned       tail [NumSem];
    int unsigned       fill [NumSem];
    sem_result_t       expected_q [$];
    int unsigned       errors;

    function new();
      active_count = RcReset;
      foreach (init_count[i]) init_count[i] = CountReset;
      foreach (head[i]) begin
        head[i] = 0;
        tail[i] = 0;
        fill[i] = 0;
      end
      errors = 0;
      reload_counts();
    endfunction

    function void reload_counts();
      foreach (avail[s]) avail[s] = (s < NumInitRegs) ? init_count[s] : '0;
    endfunction

    function void write_register(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] data);
      if (index == CFG_RESOURCE_COUNT) begin
        active_count = data[RcW-1:0];
      end else if (index >= CFG_INIT_FIRST && index <= CFG_INIT_LAST) begin
        init_count[index - CFG_INIT_FIRST] = data;
      end else begin
        return;
      end
      reload_counts();
    endfunction

    function void note_request(logic [KindW-1:0] kind, logic [IndexW-1:0] idx,
                               logic [PidW-1:0] pid);
      sem_result_t r;
      int unsigned s;
      r.woken_pid      = '0;
      r.instances_left = '0;
      s = idx;
      if (s >= active_count || s >= NumSem) begin
        r.outcome = OUT_INVALID;
      end else if (kind == KIND_WAIT) begin
        if (avail[s] != '0) begin
          avail[s]  = avail[s] - 1'b1;
          r.outcome = OUT_GRANTED;
        end else if (fill[s] >= QueueDepth) begin
          r.outcome = OUT_FULL;
        end else begin
          waiters[s][tail[s]] = pid;
          tail[s] = (tail[s] + 1) % QueueDepth;
          fill[s]++;
          r.outcome = OUT_BLOCKED;
        end
        r.instances_left = avail[s];
      end else begin
        if (fill[s] != 0) begin
          r.woken_pid = waiters[s][head[s]];
          head[s] = (head[s] + 1) % QueueDepth;
          fill[s]--;
          r.outcome = OUT_HANDED;
        end else begin
          // count saturates at the top
          if (avail[s] != CountMax) avail[s] = avail[s] + 1'b1;
          r.outcome = OUT_RELEASED;
        end
        r.instances_left = avail[s];
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OutcomeW-1:0] outcome, logic [PidW-1:0] woken_pid,
                               logic [CountW-1:0] left);
      sem_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxShown)
          $display("unexpected result: outcome %0d woken %0d left %0d",
                   outcome, woken_pid, left);
        return;
      end
      e = expected_q.pop_front();
      if (e.outcome !== outcome || e.woken_pid !== woken_pid || e.instances_left !== left)
      begin
        errors++;
        if (errors <= MaxShown)
          $display("result mismatch: expected outcome %0d woken %0d left %0d, got outcome %0d woken %0d left %0d",
                   e.outcome, e.woken_pid, e.instances_left, outcome, woken_pid, left);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  csem_cfg_if cfg_ch ();
  csem_req_if req_ch ();
  csem_res_if res_ch ();

  counting_semaphore_with_wait_queues u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  sem_scoreboard sb;
  int unsigned   hold_request = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("counting_semaphore_with_wait_queues regression: fail");
    $finish;
  end

  // result sink: checks each transfer, stalls on a rotating pattern
  initial begin
    int unsigned hold_left;
    int unsigned rx_cycle;
    hold_left = 0;
    rx_cycle  = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        sb.check_result(res_ch.outcome, res_ch.woken_pid, res_ch.instances_left);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case ((rx_cycle / 150) % 4)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= (rx_cycle % 3 == 0);
          default: res_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send_req(input logic [KindW-1:0] kind, input logic [IndexW-1:0] idx,
                          input logic [PidW-1:0] pid);
    req_ch.valid          <= 1'b1;
    req_ch.kind           <= kind;
    req_ch.resource_index <= idx;
    req_ch.requester_pid  <= pid;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    sb.note_request(kind, idx, pid);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] index, input logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    sb.write_register(index, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering requests and let every outstanding result drain
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CfgDataW-1:0] rc, input logic [CfgDataW-1:0] i0,
                            input logic [CfgDataW-1:0] i1, input logic [CfgDataW-1:0] i2,
                            input logic [CfgDataW-1:0] i3);
    write_reg(CFG_RESOURCE_COUNT, rc);
    write_reg(CFG_INIT_FIRST, i0);
    write_reg(CFG_INIT_FIRST + 3'd1, i1);
    write_reg(CFG_INIT_FIRST + 3'd2, i2);
    write_reg(CFG_INIT_LAST, i3);
  endtask

  task automatic run_items(input int unsigned n_items, input int unsigned wait_pct,
                           input int unsigned span, input int unsigned hold,
                           input int pause_at);
    int unsigned      burst_left;
    logic [KindW-1:0] kind;
    logic [IndexW-1:0] idx;
    burst_left   = $urandom_range(1, 12);
    hold_request = hold;
    for (int i = 0; i < n_items; i++) begin
      kind = ($urandom_range(0, 99) < wait_pct) ? KIND_WAIT : KIND_SIGNAL;
      // mostly in-range indices, some anywhere in the field
      if ($urandom_range(0, 9) == 0) idx = IndexW'($urandom_range(0, 15));
      else idx = IndexW'($urandom_range(0, span - 1));
      send_req(kind, idx, PidW'($urandom_range(0, 255)));
      burst_left--;
      if (i == pause_at) begin
        wait_idle();
      end else if (burst_left == 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni                <= 1'b0;
    req_ch.valid          <= 1'b0;
    req_ch.kind           <= KIND_WAIT;
    req_ch.resource_index <= '0;
    req_ch.requester_pid  <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_RESOURCE_COUNT;
    cfg_ch.data           <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // invalid indices, grant, block, handover in order, release
    send_req(KIND_WAIT, 4'd15, 8'h00);
    send_req(KIND_SIGNAL, 4'd4, 8'hFF);
    send_req(KIND_WAIT, 4'd0, 8'h01);
    send_req(KIND_WAIT, 4'd0, 8'hFF);
    send_req(KIND_WAIT, 4'd0, 8'h00);
    send_req(KIND_SIGNAL, 4'd0, 8'h02);
    send_req(KIND_SIGNAL, 4'd0, 8'h03);
    send_req(KIND_SIGNAL, 4'd0, 8'h04);
    // take the last instance, fill the queue, then overflow it
    for (int i = 0; i < 10; i++) send_req(KIND_WAIT, 4'd1, 8'h10 + 8'(i));
    wait_idle();
    // reload counts while semaphore one still has waiters
    write_reg(CFG_INIT_FIRST + 3'd1, 8'd2);
    write_reg(CFG_INIT_FIRST + 3'd2, 8'd255);
    send_req(KIND_WAIT, 4'd1, 8'h55);
    send_req(KIND_SIGNAL, 4'd1, 8'h56);
    send_req(KIND_SIGNAL, 4'd2, 8'h57);
    send_req(KIND_SIGNAL, 4'd3, 8'hAA);
    wait_idle();

    set_config(8'd4, 8'd0, 8'd0, 8'd0, 8'd0);
    run_items(350, 65, 4, 0, -1);
    wait_idle();

    // long sink hold-off while requests keep coming
    set_config(8'd1, 8'd255, 8'd255, 8'd0, 8'd0);
    run_items(300, 30, 1, 120, -1);
    wait_idle();

    set_config(8'd0, 8'd7, 8'd0, 8'd1, 8'd0);
    run_items(100, 50, 4, 0, -1);
    wait_idle();

    set_config(8'd7, 8'd3, 8'd0, 8'd255, 8'd1);
    write_reg(CfgUnusedLo, 8'd0);
    write_reg(CfgUnusedHi, 8'hFF);
    run_items(350, 50, 4, 0, -1);
    wait_idle();

    set_config(8'd2, 8'd1, 8'd2, 8'd1, 8'd1);
    run_items(350, 40, 2, 0, 170);
    wait_idle();

    // upper data bits are dropped for the resource count
    set_config(8'hFC, 8'd1, 8'd1, 8'd1, 8'd1);
    run_items(350, 50, 4, 0, -1);
    wait_idle();

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("counting_semaphore_with_wait_queues regression: pass");
    else
      $display("counting_semaphore_with_wait_queues regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
